/* design/register_use_statistics_assert.svh */
// Assertion macros for the register use statistics RTL.
`ifndef REGISTER_USE_STATISTICS_ASSERT_SVH
`define REGISTER_USE_STATISTICS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RUS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register_use_statistics: assertion failed");

// Next-cycle implication, checked outside reset.
`define RUS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register_use_statistics: assertion failed");

`endif

/* design/rus_pkg.sv */
// ----------------------------------------------------------------------------
// rus_pkg
// Shared constants and types for the register use statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rus_pkg;

   localparam int TRACK_DEPTH_DEF = 128;
   localparam int HIST_DEPTH_DEF  = 64 * 1024;
   localparam int STAMP_WIDTH_DEF = 48;

   localparam int CNT_W = 48;
   localparam int VAL_W = 64;

   // commands
   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_READ_UPD = 3'd1;
   localparam logic [2:0] CMD_WRITE    = 3'd2;
   localparam logic [2:0] CMD_WINDOW   = 3'd3;
   localparam logic [2:0] CMD_READ_OUT = 3'd4;

   // read-out tables
   localparam logic [2:0] TBL_RINT   = 3'd0;
   localparam logic [2:0] TBL_USE    = 3'd1;
   localparam logic [2:0] TBL_LIFE   = 3'd2;
   localparam logic [2:0] TBL_READS  = 3'd3;
   localparam logic [2:0] TBL_WRITES = 3'd4;
   localparam logic [2:0] TBL_SAME   = 3'd5;
   localparam logic [2:0] TBL_SUMS   = 3'd6;
   localparam logic [2:0] TBL_CNTS   = 3'd7;

   // counter selectors
   localparam logic [15:0] CNT_TOT_READS  = 16'd0;
   localparam logic [15:0] CNT_TOT_WRITES = 16'd1;
   localparam logic [15:0] CNT_FIRST      = 16'd2;
   localparam logic [15:0] CNT_LATEST     = 16'd3;
   localparam logic [15:0] CNT_STARTED    = 16'd4;

   // status codes
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_NO_ENTRY = 1'b1;

   // histogram write enables
   typedef struct packed {
      logic rint;
      logic use_h;
      logic life;
   } hist_we_type;

endpackage

/* design/rus_reg_table.sv */
// ----------------------------------------------------------------------------
// rus_reg_table
// Per-register record memory with valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rus_reg_table #(
   parameter int TRACK_DEPTH = rus_pkg::TRACK_DEPTH_DEF,
   parameter int STAMP_WIDTH = rus_pkg::STAMP_WIDTH_DEF,
   parameter int TAW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [TAW-1:0]          rd_addr,
   output logic [STAMP_WIDTH-1:0]  rd_lrs,
   output logic [STAMP_WIDTH-1:0]  rd_lws,
   output logic [rus_pkg::CNT_W-1:0] rd_rc,
   output logic [rus_pkg::CNT_W-1:0] rd_wc,
   output logic [rus_pkg::CNT_W-1:0] rd_sv,
   output logic [rus_pkg::VAL_W-1:0] rd_lv,
   input  logic                    wr_en,
   input  logic [TAW-1:0]          wr_addr,
   input  logic [STAMP_WIDTH-1:0]  wr_lrs,
   input  logic [STAMP_WIDTH-1:0]  wr_lws,
   input  logic [rus_pkg::CNT_W-1:0] wr_rc,
   input  logic [rus_pkg::CNT_W-1:0] wr_wc,
   input  logic [rus_pkg::CNT_W-1:0] wr_sv,
   input  logic [rus_pkg::VAL_W-1:0] wr_lv
);

   localparam int WW = 2 * STAMP_WIDTH + 3 * rus_pkg::CNT_W + rus_pkg::VAL_W;

   logic [WW-1:0]          mem [TRACK_DEPTH];
   logic [WW-1:0]          rd_word_ff;
   logic                   rd_vld_ff;
   logic [TRACK_DEPTH-1:0] vld_ff;
   logic [WW-1:0]          word;

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_lrs, wr_lws, wr_rc, wr_wc, wr_sv, wr_lv};
      end
      rd_word_ff <= mem[rd_addr];
   end

   // valid bits stand in for the zero reset of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign word = rd_vld_ff ? rd_word_ff : '0;
   assign {rd_lrs, rd_lws, rd_rc, rd_wc, rd_sv, rd_lv} = word;

endmodule

/* design/rus_hist_mem.sv */
// ----------------------------------------------------------------------------
// rus_hist_mem
// Three histogram memories, each with one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rus_hist_mem #(
   parameter int HIST_DEPTH = rus_pkg::HIST_DEPTH_DEF,
   parameter int HAW = $clog2(HIST_DEPTH)
) (
   input  logic                      clock,
   input  rus_pkg::hist_we_type      we,
   input  logic [HAW-1:0]            rint_rd_addr,
   input  logic [HAW-1:0]            use_rd_addr,
   input  logic [HAW-1:0]            life_rd_addr,
   input  logic [HAW-1:0]            rint_wr_addr,
   input  logic [HAW-1:0]            use_wr_addr,
   input  logic [HAW-1:0]            life_wr_addr,
   input  logic [rus_pkg::CNT_W-1:0] rint_wr_data,
   input  logic [rus_pkg::CNT_W-1:0] use_wr_data,
   input  logic [rus_pkg::CNT_W-1:0] life_wr_data,
   output logic [rus_pkg::CNT_W-1:0] rint_rd_data,
   output logic [rus_pkg::CNT_W-1:0] use_rd_data,
   output logic [rus_pkg::CNT_W-1:0] life_rd_data
);

   logic [rus_pkg::CNT_W-1:0] rint_mem [HIST_DEPTH];
   logic [rus_pkg::CNT_W-1:0] use_mem  [HIST_DEPTH];
   logic [rus_pkg::CNT_W-1:0] life_mem [HIST_DEPTH];

   // read-interval histogram
   always_ff @(posedge clock) begin
      if (we.rint) begin
         rint_mem[rint_wr_addr] <= rint_wr_data;
      end
      rint_rd_data <= rint_mem[rint_rd_addr];
   end

   // def-use histogram
   always_ff @(posedge clock) begin
      if (we.use_h) begin
         use_mem[use_wr_addr] <= use_wr_data;
      end
      use_rd_data <= use_mem[use_rd_addr];
   end

   // lifetime histogram
   always_ff @(posedge clock) begin
      if (we.life) begin
         life_mem[life_wr_addr] <= life_wr_data;
      end
      life_rd_data <= life_mem[life_rd_addr];
   end

endmodule

/* design/register_use_statistics.sv */
// ----------------------------------------------------------------------------
// register_use_statistics
// Register use statistics: per-register stamps and counts plus histograms.
// ----------------------------------------------------------------------------
// One beat is handled at a time. Unselected beats other than read out,
// out-of-range registers and unknown commands go straight to the done state;
// read update, read out and reads or writes of unwritten registers only read the
// register record; other reads and writes read the record, then do a histogram
// read-modify-write. Window done walks every tracked register (record read,
// check, and a lifetime update where a lifetime is added). After reset a
// clearing pass zeroes every histogram bin, during which req_ready is low. A
// result may wait in the output register while the next beat is taken.
`timescale 1ns / 1ps
`include "register_use_statistics_assert.svh"

module register_use_statistics #(
   parameter int TRACK_DEPTH = rus_pkg::TRACK_DEPTH_DEF,
   parameter int HIST_DEPTH  = rus_pkg::HIST_DEPTH_DEF,
   parameter int STAMP_WIDTH = rus_pkg::STAMP_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [47:0] req_instr_count,
   input  logic        req_selected,
   input  logic [7:0]  req_reg_index,
   input  logic [63:0] req_reg_value,
   input  logic [2:0]  req_table_sel,
   input  logic [15:0] req_bin_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [63:0] rsp_read_data
);

   localparam int TAW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
   localparam int HAW = $clog2(HIST_DEPTH);
   localparam int SW  = STAMP_WIDTH;
   localparam int CW  = rus_pkg::CNT_W;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CLEAR = 8'b0000_0010,
      S_REG   = 8'b0000_0100,
      S_HIST  = 8'b0000_1000,
      S_WRD   = 8'b0001_0000,
      S_WCHK  = 8'b0010_0000,
      S_WUPD  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]    cmd_ff;
   logic [SW-1:0] st_ff;
   logic [TAW-1:0] r_ff;
   logic [63:0]   val_ff;
   logic [2:0]    tsel_ff;
   logic [15:0]   idx_ff;
   logic [HAW-1:0] clr_ff;
   logic [TAW-1:0] walk_ff;
   logic [HAW-1:0] bin_rint_ff, bin_use_ff, bin_life_ff;
   logic [SW-1:0] d_rint_ff, d_use_ff, d_life_ff;
   logic          do_rl_ff;
   logic [63:0]   sum_ff [3];
   logic [CW-1:0] tot_rd_ff, tot_wr_ff, first_ff, latest_ff;
   logic          started_ff;
   logic          res_status_ff;
   logic [63:0]   res_data_ff;
   logic          rsp_valid_ff;
   logic          rsp_status_ff;
   logic [63:0]   rsp_data_ff;

   logic [TAW-1:0] reg_rd_addr;
   logic [SW-1:0]  rd_lrs, rd_lws;
   logic [CW-1:0]  rd_rc, rd_wc, rd_sv;
   logic [63:0]    rd_lv;
   logic           reg_we;
   logic [SW-1:0]  wr_lrs, wr_lws;
   logic [CW-1:0]  wr_rc, wr_wc, wr_sv;
   logic [63:0]    wr_lv;

   rus_pkg::hist_we_type hist_we;
   logic [HAW-1:0] h_rint_ra, h_use_ra, h_life_ra;
   logic [HAW-1:0] h_rint_wa, h_use_wa, h_life_wa;
   logic [CW-1:0]  h_rint_wd, h_use_wd, h_life_wd;
   logic [CW-1:0]  h_rint_rd, h_use_rd, h_life_rd;

   logic           accept, req_oor, idx_hist_oor, idx_trk_oor, rsp_free;
   logic [SW-1:0]  dr, dw, dmin, dl;

   function automatic logic [HAW-1:0] to_bin(input logic [SW-1:0] d);
      return ({1'b0, d} >= (SW+1)'(HIST_DEPTH)) ? HAW'(HIST_DEPTH - 1) : d[HAW-1:0];
   endfunction

   assign accept       = req_valid && req_ready;
   assign req_ready    = (state_ff == S_IDLE);
   assign req_oor      = ({1'b0, req_reg_index} >= 9'(TRACK_DEPTH));
   assign idx_hist_oor = ({1'b0, idx_ff} >= 17'(HIST_DEPTH));
   assign idx_trk_oor  = ({1'b0, idx_ff} >= 17'(TRACK_DEPTH));
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // gaps from the fetched record
   assign dr   = (st_ff > rd_lrs) ? st_ff - rd_lrs : '0;
   assign dw   = (st_ff > rd_lws) ? st_ff - rd_lws : '0;
   assign dmin = (dr < dw) ? dr : dw;
   assign dl   = (rd_lrs > rd_lws) ? rd_lrs - rd_lws : '0;

   rus_reg_table #(.TRACK_DEPTH(TRACK_DEPTH), .STAMP_WIDTH(SW), .TAW(TAW)) u_regs (
      .clock(clock), .reset(reset), .rd_addr(reg_rd_addr),
      .rd_lrs(rd_lrs), .rd_lws(rd_lws), .rd_rc(rd_rc), .rd_wc(rd_wc),
      .rd_sv(rd_sv), .rd_lv(rd_lv), .wr_en(reg_we), .wr_addr(r_ff),
      .wr_lrs(wr_lrs), .wr_lws(wr_lws), .wr_rc(wr_rc), .wr_wc(wr_wc),
      .wr_sv(wr_sv), .wr_lv(wr_lv)
   );

   rus_hist_mem #(.HIST_DEPTH(HIST_DEPTH), .HAW(HAW)) u_hist (
      .clock(clock), .we(hist_we),
      .rint_rd_addr(h_rint_ra), .use_rd_addr(h_use_ra), .life_rd_addr(h_life_ra),
      .rint_wr_addr(h_rint_wa), .use_wr_addr(h_use_wa), .life_wr_addr(h_life_wa),
      .rint_wr_data(h_rint_wd), .use_wr_data(h_use_wd), .life_wr_data(h_life_wd),
      .rint_rd_data(h_rint_rd), .use_rd_data(h_use_rd), .life_rd_data(h_life_rd)
   );

   // memory addressing
   always_comb begin
      reg_rd_addr = walk_ff;
      h_rint_ra   = req_bin_index[HAW-1:0];
      h_use_ra    = req_bin_index[HAW-1:0];
      h_life_ra   = req_bin_index[HAW-1:0];
      if (state_ff == S_IDLE) begin
         reg_rd_addr = (req_cmd == rus_pkg::CMD_READ_OUT) ? req_bin_index[TAW-1:0]
                                                          : req_reg_index[TAW-1:0];
      end
      if (state_ff == S_REG) begin
         h_rint_ra = to_bin(dmin);
         h_use_ra  = to_bin(dw);
         h_life_ra = to_bin(dl);
      end
      if (state_ff == S_WCHK) begin
         h_life_ra = to_bin(dl);
      end
   end

   // record write-back
   always_comb begin
      reg_we = (state_ff == S_REG) && (cmd_ff == rus_pkg::CMD_READ_UPD ||
               cmd_ff == rus_pkg::CMD_WRITE ||
               (cmd_ff == rus_pkg::CMD_READ && rd_lws != '0));
      wr_lrs = rd_lrs;
      wr_lws = rd_lws;
      wr_rc  = rd_rc;
      wr_wc  = rd_wc;
      wr_sv  = rd_sv;
      wr_lv  = rd_lv;
      case (cmd_ff)
         rus_pkg::CMD_READ: begin
            wr_rc = rd_rc + 1'b1;
         end
         rus_pkg::CMD_READ_UPD: begin
            wr_lrs = st_ff;
         end
         rus_pkg::CMD_WRITE: begin
            wr_wc  = rd_wc + 1'b1;
            wr_lws = st_ff;
            if (val_ff == rd_lv) begin
               wr_sv = rd_sv + 1'b1;
            end else begin
               wr_lv = val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // histogram write ports: clearing pass or increment
   always_comb begin
      hist_we   = '0;
      h_rint_wa = bin_rint_ff;
      h_use_wa  = bin_use_ff;
      h_life_wa = bin_life_ff;
      h_rint_wd = h_rint_rd + 1'b1;
      h_use_wd  = h_use_rd + 1'b1;
      h_life_wd = h_life_rd + 1'b1;
      if (state_ff == S_CLEAR) begin
         hist_we   = '{rint: 1'b1, use_h: 1'b1, life: 1'b1};
         h_rint_wa = clr_ff;
         h_use_wa  = clr_ff;
         h_life_wa = clr_ff;
         h_rint_wd = '0;
         h_use_wd  = '0;
         h_life_wd = '0;
      end else if (state_ff == S_HIST) begin
         hist_we.rint  = do_rl_ff;
         hist_we.use_h = do_rl_ff;
         hist_we.life  = !do_rl_ff;
      end else if (state_ff == S_WUPD) begin
         hist_we.life = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == HAW'(HIST_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (req_cmd <= rus_pkg::CMD_WRITE && req_oor) begin
                  state_in = S_DONE;
               end else if (req_cmd == rus_pkg::CMD_READ_OUT) begin
                  state_in = S_REG;
               end else if (req_cmd == rus_pkg::CMD_WINDOW && req_selected) begin
                  state_in = S_WRD;
               end else if (req_cmd <= rus_pkg::CMD_WRITE && req_selected) begin
                  state_in = S_REG;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_REG: begin
            if ((cmd_ff == rus_pkg::CMD_READ || cmd_ff == rus_pkg::CMD_WRITE) &&
                rd_lws != '0) begin
               state_in = S_HIST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_HIST: state_in = S_DONE;
         S_WRD:  state_in = S_WCHK;
         S_WCHK: begin
            if (rd_lws != '0 && dl != '0) begin
               state_in = S_WUPD;
            end else if (walk_ff == TAW'(TRACK_DEPTH - 1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WRD;
            end
         end
         S_WUPD: state_in = (walk_ff == TAW'(TRACK_DEPTH - 1)) ? S_DONE : S_WRD;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tot_rd_ff    <= '0;
         tot_wr_ff    <= '0;
         first_ff     <= '0;
         latest_ff    <= '0;
         started_ff   <= 1'b0;
         for (int k = 0; k < 3; k++) sum_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         // statistics that follow the beat directly
         if (accept && req_selected && !(req_cmd <= rus_pkg::CMD_WRITE && req_oor)) begin
            if (req_cmd == rus_pkg::CMD_READ) begin
               latest_ff <= req_instr_count;
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  first_ff   <= req_instr_count;
               end
            end
            if (req_cmd == rus_pkg::CMD_READ_UPD) tot_rd_ff <= tot_rd_ff + 1'b1;
            if (req_cmd == rus_pkg::CMD_WRITE)    tot_wr_ff <= tot_wr_ff + 1'b1;
         end
         // interval sums
         if (state_ff == S_HIST) begin
            if (do_rl_ff) begin
               sum_ff[0] <= sum_ff[0] + 64'(d_rint_ff);
               sum_ff[1] <= sum_ff[1] + 64'(d_use_ff);
            end else begin
               sum_ff[2] <= sum_ff[2] + 64'(d_life_ff);
            end
         end
         if (state_ff == S_WUPD) sum_ff[2] <= sum_ff[2] + 64'(d_life_ff);
         // output register
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // beat capture and datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_cmd;
         st_ff         <= SW'(req_instr_count);
         r_ff          <= req_reg_index[TAW-1:0];
         val_ff        <= req_reg_value;
         tsel_ff       <= req_table_sel;
         idx_ff        <= req_bin_index;
         walk_ff       <= '0;
         res_status_ff <= (req_cmd <= rus_pkg::CMD_WRITE && req_oor) ?
                          rus_pkg::ST_NO_ENTRY : rus_pkg::ST_OK;
         res_data_ff   <= '0;
      end
      if (state_ff == S_REG) begin
         bin_rint_ff <= to_bin(dmin);
         bin_use_ff  <= to_bin(dw);
         bin_life_ff <= to_bin(dl);
         d_rint_ff   <= dmin;
         d_use_ff    <= dw;
         d_life_ff   <= dl;
         do_rl_ff    <= (cmd_ff == rus_pkg::CMD_READ);
         if (cmd_ff == rus_pkg::CMD_READ_OUT) begin
            res_status_ff <= rus_pkg::ST_OK;
            res_data_ff   <= '0;
            case (tsel_ff)
               rus_pkg::TBL_RINT, rus_pkg::TBL_USE, rus_pkg::TBL_LIFE: begin
                  if (idx_hist_oor) begin
                     res_status_ff <= rus_pkg::ST_NO_ENTRY;
                  end else if (tsel_ff == rus_pkg::TBL_RINT) begin
                     res_data_ff <= 64'(h_rint_rd);
                  end else if (tsel_ff == rus_pkg::TBL_USE) begin
                     res_data_ff <= 64'(h_use_rd);
                  end else begin
                     res_data_ff <= 64'(h_life_rd);
                  end
               end
               rus_pkg::TBL_READS, rus_pkg::TBL_WRITES, rus_pkg::TBL_SAME: begin
                  if (idx_trk_oor) begin
                     res_status_ff <= rus_pkg::ST_NO_ENTRY;
                  end else if (tsel_ff == rus_pkg::TBL_READS) begin
                     res_data_ff <= 64'(rd_rc);
                  end else if (tsel_ff == rus_pkg::TBL_WRITES) begin
                     res_data_ff <= 64'(rd_wc);
                  end else begin
                     res_data_ff <= 64'(rd_sv);
                  end
               end
               rus_pkg::TBL_SUMS: begin
                  if (idx_ff >= 16'd3) begin
                     res_status_ff <= rus_pkg::ST_NO_ENTRY;
                  end else begin
                     res_data_ff <= sum_ff[idx_ff[1:0]];
                  end
               end
               default: begin
                  case (idx_ff)
                     rus_pkg::CNT_TOT_READS:  res_data_ff <= 64'(tot_rd_ff);
                     rus_pkg::CNT_TOT_WRITES: res_data_ff <= 64'(tot_wr_ff);
                     rus_pkg::CNT_FIRST:      res_data_ff <= 64'(first_ff);
                     rus_pkg::CNT_LATEST:     res_data_ff <= 64'(latest_ff);
                     rus_pkg::CNT_STARTED:    res_data_ff <= 64'(started_ff);
                     default:                 res_status_ff <= rus_pkg::ST_NO_ENTRY;
                  endcase
               end
            endcase
         end
      end
      // window walk
      if (state_ff == S_WCHK) begin
         bin_life_ff <= to_bin(dl);
         d_life_ff   <= dl;
      end
      if ((state_ff == S_WCHK && state_in == S_WRD) || state_ff == S_WUPD) begin
         walk_ff <= walk_ff + 1'b1;
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

   `RUS_ASSERT_IMP(a_no_accept_in_clear, clock, reset, state_ff == S_CLEAR, !req_ready)
   `RUS_ASSERT_NXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `RUS_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                   $past(state_ff) == S_DONE)

endmodule

/* bench/tb_register_use_statistics.sv */
// ----------------------------------------------------------------------------
// tb_register_use_statistics
// Self-checking bench for the register use statistics block. A queue of
// request beats (directed first, then random traffic, mostly read, read
// update and write runs) feeds a clocked driver; a predictor updated on each
// accepted beat queues the expected response, and a monitor compares every
// response beat field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_use_statistics;

   localparam int NREGS  = 128;
   localparam int NBINS  = 65536;
   localparam int N_RAND = 850;

   typedef struct {
      logic [2:0]  cmd;
      logic [47:0] instr;
      logic        sel;
      logic [7:0]  ridx;
      logic [63:0] val;
      logic [2:0]  tsel;
      logic [15:0] bin;
      bit          drain;   // marker: hold off until all responses are back
   } req_beat_type;

   typedef struct {
      logic        status;
      logic [63:0] data;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [47:0] req_instr_count = '0;
   logic        req_selected = 1'b0;
   logic [7:0]  req_reg_index = '0;
   logic [63:0] req_reg_value = '0;
   logic [2:0]  req_table_sel = '0;
   logic [15:0] req_bin_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [63:0] rsp_read_data;

   register_use_statistics DUT (.*);

   always #5 clock = ~clock;

   // ---------------- predicted block state ----------------
   logic [47:0] rd_stamp [NREGS];
   logic [47:0] wr_stamp [NREGS];
   logic [47:0] n_reads  [NREGS];
   logic [47:0] n_writes [NREGS];
   logic [63:0] held_val [NREGS];
   logic [47:0] n_same   [NREGS];
   logic [47:0] rint_hist [NBINS];
   logic [47:0] use_hist  [NBINS];
   logic [47:0] life_hist [NBINS];
   logic [63:0] gap_sums [3];
   logic [47:0] tot_reads, tot_writes, first_seen, latest_seen;
   logic        started;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];
   int        fail_count = 0;
   int        sent_beats = 0;
   int        rsp_beats = 0;
   bit        offer_taken = 0;

   function automatic logic [47:0] clamp_gap(logic [47:0] later, logic [47:0] earlier);
      return (later > earlier) ? later - earlier : 48'd0;
   endfunction

   function automatic void add_sample(int which, logic [47:0] d);
      int b;
      b = (d >= NBINS) ? NBINS - 1 : int'(d);
      gap_sums[which] += {16'd0, d};
      case (which)
         0: rint_hist[b] += 48'd1;
         1: use_hist[b]  += 48'd1;
         default: life_hist[b] += 48'd1;
      endcase
   endfunction

   // Apply one request beat to the predicted state, return its response
   function automatic rsp_beat_type apply_stats(req_beat_type q);
      rsp_beat_type r;
      int          x;
      logic [47:0] dr, dw;
      r.status = rus_pkg::ST_OK;
      r.data   = '0;
      x = int'(q.ridx);
      if (q.cmd <= rus_pkg::CMD_WRITE && q.ridx >= NREGS) begin
         r.status = rus_pkg::ST_NO_ENTRY;
         return r;
      end
      case (q.cmd)
         rus_pkg::CMD_READ: if (q.sel) begin
            latest_seen = q.instr;
            if (!started) begin
               started = 1'b1;
               first_seen = q.instr;
            end
            if (wr_stamp[x] != 0) begin
               dr = clamp_gap(q.instr, rd_stamp[x]);
               dw = clamp_gap(q.instr, wr_stamp[x]);
               n_reads[x] += 48'd1;
               add_sample(0, (dr < dw) ? dr : dw);
               add_sample(1, dw);
            end
         end
         rus_pkg::CMD_READ_UPD: if (q.sel) begin
            tot_reads += 48'd1;
            rd_stamp[x] = q.instr;
         end
         rus_pkg::CMD_WRITE: if (q.sel) begin
            tot_writes += 48'd1;
            n_writes[x] += 48'd1;
            if (q.val == held_val[x]) n_same[x] += 48'd1;
            else held_val[x] = q.val;
            if (wr_stamp[x] != 0) add_sample(2, clamp_gap(rd_stamp[x], wr_stamp[x]));
            wr_stamp[x] = q.instr;
         end
         rus_pkg::CMD_WINDOW: if (q.sel) begin
            for (int i = 0; i < NREGS; i++)
               if (wr_stamp[i] != 0 && clamp_gap(rd_stamp[i], wr_stamp[i]) > 0)
                  add_sample(2, clamp_gap(rd_stamp[i], wr_stamp[i]));
         end
         rus_pkg::CMD_READ_OUT: begin
            case (q.tsel)
               rus_pkg::TBL_RINT, rus_pkg::TBL_USE, rus_pkg::TBL_LIFE:
                  r.data = (q.tsel == rus_pkg::TBL_RINT) ? 64'(rint_hist[q.bin])
                         : (q.tsel == rus_pkg::TBL_USE) ? 64'(use_hist[q.bin])
                                                        : 64'(life_hist[q.bin]);
               rus_pkg::TBL_READS, rus_pkg::TBL_WRITES, rus_pkg::TBL_SAME:
                  if (q.bin >= NREGS) r.status = rus_pkg::ST_NO_ENTRY;
                  else r.data = (q.tsel == rus_pkg::TBL_READS) ? 64'(n_reads[q.bin])
                              : (q.tsel == rus_pkg::TBL_WRITES) ? 64'(n_writes[q.bin])
                                                                : 64'(n_same[q.bin]);
               rus_pkg::TBL_SUMS:
                  if (q.bin >= 3) r.status = rus_pkg::ST_NO_ENTRY;
                  else r.data = gap_sums[q.bin];
               default:
                  case (q.bin)
                     rus_pkg::CNT_TOT_READS:  r.data = 64'(tot_reads);
                     rus_pkg::CNT_TOT_WRITES: r.data = 64'(tot_writes);
                     rus_pkg::CNT_FIRST:      r.data = 64'(first_seen);
                     rus_pkg::CNT_LATEST:     r.data = 64'(latest_seen);
                     rus_pkg::CNT_STARTED:    r.data = 64'(started);
                     default:                 r.status = rus_pkg::ST_NO_ENTRY;
                  endcase
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_beat(logic [2:0] c, logic [47:0] n, logic s, logic [7:0] ri,
                                    logic [63:0] v, logic [2:0] t, logic [15:0] b);
      req_beat_type q;
      q.cmd = c; q.instr = n; q.sel = s; q.ridx = ri; q.val = v; q.tsel = t; q.bin = b;
      q.drain = 0;
      pending_reqs.push_back(q);
   endfunction

   function automatic void add_drain();
      req_beat_type q;
      q = '{default: 0};
      q.drain = 1;
      pending_reqs.push_back(q);
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(5))
         0: return 64'd0;
         1: return 64'd1;
         2: return '1;
         3: return 64'hA5A5_5A5A_0F0F_F0F0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [15:0] pick_bin(logic [2:0] t);
      int k;
      k = $urandom_range(9);
      case (t)
         rus_pkg::TBL_RINT, rus_pkg::TBL_USE, rus_pkg::TBL_LIFE:
            return (k < 6) ? 16'($urandom_range(40)) : (k < 8) ? 16'hFFFF : 16'($urandom);
         rus_pkg::TBL_READS, rus_pkg::TBL_WRITES, rus_pkg::TBL_SAME:
            return (k < 8) ? 16'($urandom_range(NREGS - 1)) : 16'($urandom);
         rus_pkg::TBL_SUMS: return 16'($urandom_range(3));
         default:  return (k < 8) ? 16'($urandom_range(5)) : 16'($urandom);
      endcase
   endfunction

   // ---------------- stimulus ----------------
   initial begin
      logic [47:0] now;
      logic [7:0]  r;
      logic [2:0]  t;
      int          k;
      foreach (rd_stamp[i]) begin
         rd_stamp[i] = 0; wr_stamp[i] = 0; n_reads[i] = 0;
         n_writes[i] = 0; held_val[i] = 0; n_same[i] = 0;
      end
      for (int i = 0; i < NBINS; i++) begin
         rint_hist[i] = 0; use_hist[i] = 0; life_hist[i] = 0;
      end
      gap_sums = '{default: 0};
      tot_reads = 0; tot_writes = 0; first_seen = 0; latest_seen = 0; started = 0;

      // directed: unwritten register, zero stamp, saturation, out of range
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_CNTS, rus_pkg::CNT_STARTED);
      add_beat(rus_pkg::CMD_WRITE, 0, 1, 0, 64'h1234, 0, 0);  // write at zero looks unwritten
      add_beat(rus_pkg::CMD_READ, 5, 1, 0, 0, 0, 0);
      add_beat(rus_pkg::CMD_WRITE, 10, 1, 1, '1, 0, 0);
      add_beat(rus_pkg::CMD_READ_UPD, 12, 1, 1, 0, 0, 0);
      add_beat(rus_pkg::CMD_READ, 15, 1, 1, 0, 0, 0);
      add_beat(rus_pkg::CMD_READ, 16, 0, 1, 0, 0, 0);         // unselected
      add_beat(rus_pkg::CMD_WRITE, 20, 1, 1, '1, 0, 0);       // same value rewrite
      add_beat(rus_pkg::CMD_WRITE, 21, 1, 8'hFF, 0, 0, 0);
      add_beat(rus_pkg::CMD_READ, 22, 0, 8'd128, 0, 0, 0);
      add_beat(rus_pkg::CMD_WRITE, 100, 1, 127, 64'h55, 0, 0);
      add_beat(rus_pkg::CMD_READ_UPD, 90, 1, 127, 0, 0, 0);   // negative gap
      add_beat(rus_pkg::CMD_READ, 70200, 1, 127, 0, 0, 0);    // saturating gap
      add_beat(rus_pkg::CMD_READ_UPD, 70300, 1, 127, 0, 0, 0);
      add_beat(rus_pkg::CMD_WINDOW, 70400, 1, 8'hAB, 0, 0, 0);
      add_beat(rus_pkg::CMD_WINDOW, 70400, 0, 0, 0, 0, 0);
      add_beat(3'd7, 70500, 1, 3, '1, 7, 16'hFFFF);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 1, 0, 0, rus_pkg::TBL_RINT, 16'hFFFF);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_USE, 16'hFFFF);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_LIFE, 8);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_SAME, 1);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_WRITES, 128);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_SUMS, 3);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_CNTS, 5);
      add_beat(rus_pkg::CMD_READ_OUT, 0, 0, 0, 0, rus_pkg::TBL_CNTS, rus_pkg::CNT_FIRST);
      add_drain();

      // random traffic, mostly read / read update / write runs on few registers
      now = 70600;
      for (int i = 0; i < N_RAND; i++) begin
         if (i == 400 || i == 700) add_drain();
         k = $urandom_range(99);
         if (k < 70) now += $urandom_range(12);
         else if (k < 85) now += $urandom_range(300, 13);
         else if (k < 95) now += $urandom_range(200000, 60000);
         else now = 48'({$urandom, $urandom});
         k = $urandom_range(99);
         r = (k < 60) ? 8'($urandom_range(15)) : (k < 95) ? 8'($urandom_range(NREGS - 1))
                                                          : 8'($urandom_range(255, NREGS));
         k = $urandom_range(99);
         if (k < 30) begin
            add_beat(rus_pkg::CMD_READ, now, 1, r, {$urandom, $urandom}, 3'($urandom),
                     16'($urandom));
            add_beat(rus_pkg::CMD_READ_UPD, now, 1, r, 0, 0, 0);
         end
         else if (k < 55) add_beat(rus_pkg::CMD_WRITE, now, 1, r, pick_value(), 0, 0);
         else if (k < 63) add_beat(rus_pkg::CMD_READ, now, 1, r, 0, 0, 0);
         else if (k < 68) add_beat(rus_pkg::CMD_READ_UPD, now, 1, r, 0, 0, 0);
         else if (k < 85) begin
            t = 3'($urandom);
            add_beat(rus_pkg::CMD_READ_OUT, now, 1'($urandom), r, 0, t, pick_bin(t));
         end
         else if (k < 88) add_beat(rus_pkg::CMD_WINDOW, now, 1, r, 0, 0, 0);
         else if (k < 91) add_beat(3'($urandom_range(7, 5)), now, 1, r, pick_value(),
                                   3'($urandom), 16'($urandom));
         else add_beat(3'($urandom_range(3)), now, 0, r, pick_value(), 0, 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_valid);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("register_use_statistics verification clean");
      else
         $display("register_use_statistics verification failed");
      $finish;
   end

   initial begin
      #10ms;
      $display("register_use_statistics verification failed");
      $finish;
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(apply_stats('{req_cmd, req_instr_count, req_selected,
            req_reg_index, req_reg_value, req_table_sel, req_bin_index, 1'b0}));
         sent_beats++;
         offer_taken = 1;
      end
   end

   always @(negedge clock) begin
      req_beat_type q;
      bit        idle;
      if (!reset && (!req_valid || offer_taken)) begin
         offer_taken = 0;
         idle = ($urandom_range(99) < 29) && !(sent_beats >= 400 && sent_beats < 550);
         if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
            if (expected_rsps.size() == 0) void'(pending_reqs.pop_front());
            req_valid <= 1'b0;
         end
         else if (pending_reqs.size() == 0 || idle) req_valid <= 1'b0;
         else begin
            q = pending_reqs.pop_front();
            req_valid       <= 1'b1;
            req_cmd         <= q.cmd;
            req_instr_count <= q.instr;
            req_selected    <= q.sel;
            req_reg_index   <= q.ridx;
            req_reg_value   <= q.val;
            req_table_sel   <= q.tsel;
            req_bin_index   <= q.bin;
         end
      end
   end

   // ---------------- response side ----------------
   int hold_cycles = 0;
   always @(negedge clock) begin
      if (rsp_beats == 300 && hold_cycles < 250) begin
         hold_cycles++;          // long hold-off so the block backs up
         rsp_ready <= 1'b0;
      end
      else if (rsp_beats >= 600 && rsp_beats < 750) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         if (expected_rsps.size() == 0) begin
            if (fail_count < 10)
               $display("ERROR: response beat with none expected: status %0d data %h",
                        rsp_status, rsp_read_data);
            fail_count++;
         end
         else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_read_data !== e.data) begin
               if (fail_count < 10)
                  $display("ERROR: beat %0d: status %0d data %h, expected status %0d data %h",
                           rsp_beats, rsp_status, rsp_read_data, e.status, e.data);
               fail_count++;
            end
         end
      end
   end

endmodule

/* files.f */
+incdir+design
design/rus_pkg.sv
design/rus_reg_table.sv
design/rus_hist_mem.sv
design/register_use_statistics.sv
bench/tb_register_use_statistics.sv
